### rtl/core/unicycle_odometry_integrator_core_defines.svh
// Assertion macros shared by the odometry core.
`ifndef UNICYCLE_ODOMETRY_INTEGRATOR_CORE_DEFINES_SVH
`define UNICYCLE_ODOMETRY_INTEGRATOR_CORE_DEFINES_SVH

// Same-cycle implication under synchronous reset.
`define UOI_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication under synchronous reset.
`define UOI_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/core/uoi_pkg.sv
`timescale 1ns / 1ps
package uoi_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int STEP_W       = 5;

  localparam logic signed [33:0] GAIN_Q30   = 34'sd652032875;
  localparam logic signed [31:0] TURN_SCALE = 32'sd683565276;

  // multiply step codes
  localparam logic [2:0] MOP_NONE = 3'd0;
  localparam logic [2:0] MOP_LC   = 3'd1;
  localparam logic [2:0] MOP_LCDT = 3'd2;
  localparam logic [2:0] MOP_LS   = 3'd3;
  localparam logic [2:0] MOP_LSDT = 3'd4;
  localparam logic [2:0] MOP_AD   = 3'd5;
  localparam logic [2:0] MOP_ADT  = 3'd6;

  // CORDIC angle source
  localparam logic SEL_HEAD = 1'b0;
  localparam logic SEL_HALF = 1'b1;

  typedef struct packed {
    logic              load_cmd;
    logic              load_dt;
    logic              cord_init;
    logic              cord_sel;
    logic              cord_step;
    logic [STEP_W-1:0] step_idx;
    logic [2:0]        mop;
    logic              upd;
    logic              out_load;
  } uoi_cmd_t;

  typedef struct packed {
    logic enabled;
    logic out_free;
    logic dt_zero;
  } uoi_stat_t;

  function automatic logic [31:0] atan_lut(input logic [STEP_W-1:0] i);
    logic [31:0] v;
    unique case (i)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA;
      5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;
      5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C;
      5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3;
      5'd23: v = 32'h00000051;
      default: v = 32'h0;
    endcase
    return v;
  endfunction

  function automatic logic [15:0] to_q15(input logic signed [33:0] v);
    logic signed [34:0] r;
    logic signed [19:0] q;
    r = $signed({v[33], v}) + 35'sd16384;
    q = r[34:15];
    if (q > 20'sd32767) return 16'h7FFF;
    if (q < -20'sd32768) return 16'h8000;
    return q[15:0];
  endfunction

endpackage

### rtl/core/uoi_ctrl.sv
`timescale 1ns / 1ps
`include "unicycle_odometry_integrator_core_defines.svh"
module uoi_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  input  logic                in_mode,
  output logic                in_tready,
  input  uoi_pkg::uoi_stat_t  stat,
  output uoi_pkg::uoi_cmd_t   cmd
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_C1   = 4'd1;
  localparam logic [3:0] S_M1   = 4'd2;
  localparam logic [3:0] S_M2   = 4'd3;
  localparam logic [3:0] S_M3   = 4'd4;
  localparam logic [3:0] S_M4   = 4'd5;
  localparam logic [3:0] S_M5   = 4'd6;
  localparam logic [3:0] S_M6   = 4'd7;
  localparam logic [3:0] S_UPD  = 4'd8;
  localparam logic [3:0] S_C2I  = 4'd9;
  localparam logic [3:0] S_C2   = 4'd10;
  localparam logic [3:0] S_OUT  = 4'd11;

  localparam logic [uoi_pkg::STEP_W-1:0] LAST_STEP =
    uoi_pkg::STEP_W'(uoi_pkg::CORDIC_STEPS - 1);

  logic [3:0]                   state_r, state_nxt;
  logic [uoi_pkg::STEP_W-1:0]   cnt_r, cnt_nxt;
  logic                         acc;

  assign in_tready = (state_r == S_IDLE);
  assign acc       = in_tvalid && in_tready;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    cmd.step_idx = cnt_r;
    cmd.mop      = uoi_pkg::MOP_NONE;
    unique case (state_r)
      S_IDLE: begin
        if (acc) begin
          if (!in_mode) begin
            cmd.load_cmd = 1'b1;
          end else if (!stat.dt_zero) begin
            cmd.load_dt   = 1'b1;
            cmd.cord_init = 1'b1;
            cnt_nxt       = '0;
            if (stat.enabled) begin
              cmd.cord_sel = uoi_pkg::SEL_HEAD;
              state_nxt    = S_C1;
            end else begin
              cmd.cord_sel = uoi_pkg::SEL_HALF;
              state_nxt    = S_C2;
            end
          end
        end
      end
      S_C1, S_C2: begin
        cmd.cord_step = 1'b1;
        cnt_nxt       = cnt_r + 1'b1;
        if (cnt_r == LAST_STEP) begin
          state_nxt = (state_r == S_C1) ? S_M1 : S_OUT;
        end
      end
      S_M1: begin cmd.mop = uoi_pkg::MOP_LC;   state_nxt = S_M2; end
      S_M2: begin cmd.mop = uoi_pkg::MOP_LCDT; state_nxt = S_M3; end
      S_M3: begin cmd.mop = uoi_pkg::MOP_LS;   state_nxt = S_M4; end
      S_M4: begin cmd.mop = uoi_pkg::MOP_LSDT; state_nxt = S_M5; end
      S_M5: begin cmd.mop = uoi_pkg::MOP_AD;   state_nxt = S_M6; end
      S_M6: begin cmd.mop = uoi_pkg::MOP_ADT;  state_nxt = S_UPD; end
      S_UPD: begin
        cmd.upd   = 1'b1;
        state_nxt = S_C2I;
      end
      S_C2I: begin
        cmd.cord_init = 1'b1;
        cmd.cord_sel  = uoi_pkg::SEL_HALF;
        cnt_nxt       = '0;
        state_nxt     = S_C2;
      end
      S_OUT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  `UOI_ASSERT_NOW(a_step_range, clk, rst_n, cmd.cord_step, cnt_r <= LAST_STEP, "step past table")
  `UOI_ASSERT_NOW(a_load_free, clk, rst_n, cmd.out_load, stat.out_free, "result overwritten")
  `UOI_ASSERT_NEXT(a_tick_busy, clk, rst_n, cmd.load_dt, !in_tready, "tick did not start work")
  `UOI_ASSERT_NEXT(a_upd_init, clk, rst_n, cmd.upd, cmd.cord_init && cmd.cord_sel == uoi_pkg::SEL_HALF, "quaternion pass skipped")

endmodule

### rtl/core/uoi_dp.sv
`timescale 1ns / 1ps
module uoi_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  uoi_pkg::uoi_cmd_t   cmd,
  output uoi_pkg::uoi_stat_t  stat,
  input  logic [47:0]         in_tdata,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [159:0]        out_tdata,
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [2:0]          cfg_paddr,
  input  logic [31:0]         cfg_pwdata,
  output logic [31:0]         cfg_prdata
);

  logic [14:0]        speed_cap_r;
  logic               enabled_r;
  logic signed [31:0] x_r, y_r;
  logic [31:0]        head_r;
  logic signed [15:0] lin_r, ang_r;
  logic [15:0]        dt_r;
  logic signed [33:0] cx_r, cy_r, cz_r;
  logic               flip_r;
  logic signed [49:0] t_r;
  logic signed [63:0] px_r, py_r, ph_r;
  logic               ov_r;
  logic [159:0]       od_r;

  logic signed [15:0] lin_in, ang_in;
  logic signed [16:0] lin_cl, lim;
  logic [31:0]        ang_src, ang_red;
  logic signed [33:0] xs, ys, atn, c_v, s_v;
  logic signed [64:0] rx, ry, rh;
  logic signed [32:0] sx, sy;
  logic               cfg_wr;

  assign lin_in = in_tdata[15:0];
  assign ang_in = in_tdata[31:16];
  assign lim    = $signed({2'b00, speed_cap_r});

  always_comb begin
    if ($signed({lin_in[15], lin_in}) > lim) lin_cl = lim;
    else if ($signed({lin_in[15], lin_in}) < -lim) lin_cl = -lim;
    else lin_cl = {lin_in[15], lin_in};
  end

  assign ang_src = (cmd.cord_sel == uoi_pkg::SEL_HALF) ? {1'b0, head_r[31:1]} : head_r;
  assign ang_red = {ang_src[31] ^ (ang_src[31] ^ ang_src[30]), ang_src[30:0]};
  assign xs  = cx_r >>> cmd.step_idx;
  assign ys  = cy_r >>> cmd.step_idx;
  assign atn = $signed({2'b00, uoi_pkg::atan_lut(cmd.step_idx)});
  assign c_v = flip_r ? -cx_r : cx_r;
  assign s_v = flip_r ? -cy_r : cy_r;

  assign rx = ($signed({px_r[63], px_r}) + 65'sh200_0000_0000) >>> 42;
  assign ry = ($signed({py_r[63], py_r}) + 65'sh200_0000_0000) >>> 42;
  assign rh = ($signed({ph_r[63], ph_r}) + 65'sh800_0000) >>> 28;
  assign sx = $signed({x_r[31], x_r}) + rx[32:0];
  assign sy = $signed({y_r[31], y_r}) + ry[32:0];

  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_prdata = cfg_paddr[2] ? {31'd0, enabled_r} : {17'd0, speed_cap_r};

  assign stat.enabled  = enabled_r;
  assign stat.out_free = !ov_r || out_tready;
  assign stat.dt_zero  = (in_tdata[47:32] == 16'd0);

  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_cap_r <= 15'd4096;
      enabled_r   <= 1'b1;
      x_r         <= '0;
      y_r         <= '0;
      head_r      <= '0;
      lin_r       <= '0;
      ang_r       <= '0;
      ov_r        <= 1'b0;
    end else begin
      if (cfg_wr) begin
        if (cfg_paddr[2]) enabled_r <= cfg_pwdata[0];
        else speed_cap_r <= cfg_pwdata[14:0];
      end
      if (cmd.load_cmd) begin
        lin_r <= lin_cl[15:0];
        ang_r <= ang_in;
      end
      if (cmd.upd) begin
        // saturate position, wrap heading
        if (sx > 33'sh0_7FFF_FFFF) x_r <= 32'sh7FFF_FFFF;
        else if (sx < -33'sh0_8000_0000) x_r <= 32'sh8000_0000;
        else x_r <= sx[31:0];
        if (sy > 33'sh0_7FFF_FFFF) y_r <= 32'sh7FFF_FFFF;
        else if (sy < -33'sh0_8000_0000) y_r <= 32'sh8000_0000;
        else y_r <= sy[31:0];
        head_r <= head_r + rh[31:0];
      end
      if (cmd.out_load) ov_r <= 1'b1;
      else if (out_tready) ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_dt) dt_r <= in_tdata[47:32];
    if (cmd.cord_init) begin
      // fold the left half-plane back and negate the outputs afterwards
      flip_r <= ang_src[31] ^ ang_src[30];
      cx_r   <= uoi_pkg::GAIN_Q30;
      cy_r   <= '0;
      cz_r   <= $signed({{2{ang_red[31]}}, ang_red});
    end else if (cmd.cord_step) begin
      if (!cz_r[33]) begin
        cx_r <= cx_r - ys;
        cy_r <= cy_r + xs;
        cz_r <= cz_r - atn;
      end else begin
        cx_r <= cx_r + ys;
        cy_r <= cy_r - xs;
        cz_r <= cz_r + atn;
      end
    end
    unique case (cmd.mop)
      uoi_pkg::MOP_LC:   t_r  <= 50'(lin_r * c_v);
      uoi_pkg::MOP_LCDT: px_r <= 64'(t_r * $signed({1'b0, dt_r}));
      uoi_pkg::MOP_LS:   t_r  <= 50'(lin_r * s_v);
      uoi_pkg::MOP_LSDT: py_r <= 64'(t_r * $signed({1'b0, dt_r}));
      uoi_pkg::MOP_AD:   t_r  <= 50'(ang_r * $signed({1'b0, dt_r}));
      // rate times dt always fits in 32 signed bits
      uoi_pkg::MOP_ADT:  ph_r <= 64'($signed(t_r[31:0]) * uoi_pkg::TURN_SCALE);
      default: ;
    endcase
    if (cmd.out_load) begin
      od_r <= {ang_r, lin_r, uoi_pkg::to_q15(c_v), uoi_pkg::to_q15(s_v),
               head_r, y_r, x_r};
    end
  end

endmodule

### rtl/core/unicycle_odometry_integrator_core.sv
`timescale 1ns / 1ps
// Channel  Dir  Beat contents
// in       in   tdata: lin_cmd, ang_cmd, dt; tuser: mode (1 = time tick)
// out      out  tdata: pos_x, pos_y, heading, quat_z, quat_w, lin_echo, ang_echo
// cfg      in   APB, 0x0 speed clamp, 0x4 enabled
//
// A velocity command is loaded on acceptance. A nonzero-dt tick runs a CORDIC
// pass on the heading, the multiply steps, the update and a half-heading CORDIC
// pass when enabled, only the half-heading pass when disabled; both passes share
// one CORDIC iteration loop. A zero-dt tick is dropped. Reset is synchronous,
// active low. The result register holds one transaction; a new item is taken
// while it waits, and a tick stalls only at its end until the result is taken.
module unicycle_odometry_integrator_core (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [47:0]  in_tdata,   // lin_cmd[15:0], ang_cmd[31:16], dt[47:32]
  input  logic         in_tuser,   // mode
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [159:0] out_tdata,  // pos_x, pos_y, heading, quat_z, quat_w, lin_echo, ang_echo
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [2:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);

  uoi_pkg::uoi_cmd_t  cmd;
  uoi_pkg::uoi_stat_t stat;

  assign cfg_pready = 1'b1;

  uoi_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_mode   (in_tuser),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  uoi_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .stat        (stat),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata)
  );

endmodule
